[sv/cpf_pkg.sv]
// Shared types and constants for the command packet framer.
`default_nettype none
package cpf_pkg;

    localparam int PAYLOAD_MAX = 56;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int IDX_W       = 6;
    localparam int HDR_BYTES   = 8;

    localparam logic [7:0] HDR_SEC_BYTE = 8'hC0;
    localparam logic [7:0] HDR_ZERO     = 8'h00;
    localparam logic [7:0] CKS_SEED     = 8'hFF;
    localparam logic [7:0] LEN_BIAS     = 8'h01;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    typedef struct packed {
        logic begin_pkt;
        logic append_byte;
        logic start_emit;
        logic fetch_en;
    } t_dp_ctl;

    typedef struct packed {
        logic fetch_done;
    } t_dp_sts;

endpackage
`default_nettype wire

[sv/cpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/cpf_ctrl.sv]
// Controller state machine: input handshake and emit sequencing.
`default_nettype none
module cpf_ctrl
    import cpf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic [1:0] i_command,
    input  wire t_dp_sts i_sts,
    output logic         o_in_stall,
    output t_dp_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    t_cmd   cmd;

    assign cmd    = t_cmd'(i_command);
    assign in_acc = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && cmd == CMD_FINISH) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.fetch_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall        = (r_state == ST_EMIT);
        o_ctl.begin_pkt   = 1'b0;
        o_ctl.append_byte = 1'b0;
        o_ctl.start_emit  = 1'b0;
        o_ctl.fetch_en    = (r_state == ST_EMIT);
        if (in_acc) begin
            unique case (cmd)
                CMD_BEGIN:  o_ctl.begin_pkt   = 1'b1;
                CMD_APPEND: o_ctl.append_byte = 1'b1;
                CMD_FINISH: o_ctl.start_emit  = 1'b1;
                CMD_UNUSED: ;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/cpf_datapath.sv]
// Datapath: packet state, payload RAM, fetch stage and output register.
`default_nettype none
module cpf_datapath
    import cpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_ctl     i_ctl,
    input  wire logic [15:0] i_message_id,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_stall,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic [7:0]       o_packet_byte,
    output logic             o_last_in_packet,
    output logic             o_overflow_seen
);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_xor;
    logic [15:0]      r_msg_id;
    logic [7:0]       r_func;
    logic             r_ovf;
    logic [IDX_W-1:0] r_idx;

    logic             r_p_valid;
    logic             r_p_hdr_sel;
    logic [7:0]       r_p_hdr;
    logic             r_p_last;
    logic             r_p_ovf;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_ovf;

    logic             not_full;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic             out_load;
    logic             p_load;
    logic             idx_is_last;
    logic             idx_is_hdr;
    logic [7:0]       len_byte;
    logic [7:0]       cks_byte;
    logic [7:0]       hdr_byte;

    assign not_full = (r_count < CNT_W'(PAYLOAD_MAX));
    assign ram_we   = i_ctl.append_byte && not_full;

    assign out_load    = r_p_valid && (!r_out_valid || !i_out_stall);
    assign p_load      = i_ctl.fetch_en && (!r_p_valid || out_load);
    assign idx_is_hdr  = (r_idx < IDX_W'(HDR_BYTES));
    assign idx_is_last = ({1'b0, r_idx} == ((IDX_W + 1)'(r_count) + (IDX_W + 1)'(HDR_BYTES - 1)));
    assign ram_re      = p_load && !idx_is_hdr;

    assign len_byte = 8'(r_count) + LEN_BIAS;
    assign cks_byte = CKS_SEED ^ r_msg_id[15:8] ^ r_msg_id[7:0] ^ HDR_SEC_BYTE
                    ^ len_byte ^ r_func ^ r_xor;

    always_comb begin
        unique case (r_idx[2:0])
            3'd0:    hdr_byte = r_msg_id[15:8];
            3'd1:    hdr_byte = r_msg_id[7:0];
            3'd2:    hdr_byte = HDR_SEC_BYTE;
            3'd3:    hdr_byte = HDR_ZERO;
            3'd4:    hdr_byte = HDR_ZERO;
            3'd5:    hdr_byte = len_byte;
            3'd6:    hdr_byte = r_func;
            3'd7:    hdr_byte = cks_byte;
            default: hdr_byte = HDR_ZERO;
        endcase
    end

    cpf_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(r_count)),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ADDR_W'(r_idx - IDX_W'(HDR_BYTES))),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_xor     <= '0;
            r_msg_id  <= '0;
            r_func    <= '0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            r_p_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.begin_pkt) begin
                r_msg_id <= i_message_id;
                r_func   <= i_function_code;
                r_count  <= '0;
                r_xor    <= '0;
                r_ovf    <= 1'b0;
            end else if (i_ctl.append_byte) begin
                if (not_full) begin
                    r_count <= r_count + CNT_W'(1);
                    r_xor   <= r_xor ^ i_data_byte;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_ctl.start_emit) begin
                r_idx <= '0;
            end else if (p_load) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (p_load) begin
                r_p_valid <= 1'b1;
            end else if (out_load) begin
                r_p_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_load) begin
            r_p_hdr_sel <= idx_is_hdr;
            r_p_hdr     <= hdr_byte;
            r_p_last    <= idx_is_last;
            r_p_ovf     <= r_ovf;
        end
        if (out_load) begin
            r_out_byte <= r_p_hdr_sel ? r_p_hdr : ram_rdata;
            r_out_last <= r_p_last;
            r_out_ovf  <= r_p_ovf;
        end
    end

    assign o_sts.fetch_done = p_load && idx_is_last;
    assign o_out_valid      = r_out_valid;
    assign o_packet_byte    = r_out_byte;
    assign o_last_in_packet = r_out_last;
    assign o_overflow_seen  = r_out_ovf;

endmodule
`default_nettype wire

[sv/command_packet_framer_unit.sv]
// Top level of the command packet framer: controller plus datapath.
//
// Channel    Direction  Handshake               Fields
// request in input      i_in_valid / o_in_stall i_command, i_message_id,
//                                                i_function_code, i_data_byte
// packet out output     o_out_valid / i_out_stall o_packet_byte,
//                                                o_last_in_packet, o_overflow_seen
//
// Begin and append requests are accepted back to back.
// A finish request stalls the input while the fetch stage walks the header mux and
// the payload RAM read port, one byte per cycle while the output does not stall.
// Output bytes pass a fetch register and an output register, so the input reopens
// while the last two bytes of a packet still drain.
// Output stalls hold both registers and pause the fetch walk; nothing is lost.
// Synchronous active-low reset clears the controller, counters and valid flags.
// The payload RAM needs no clearing: only entries written since the last begin
// are ever read.
`default_nettype none
module command_packet_framer_unit
    import cpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_message_id,
    input  wire logic [7:0]  i_function_code,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_packet_byte,
    output logic             o_last_in_packet,
    output logic             o_overflow_seen
);

    // Commands from controller to datapath and status back.
    t_dp_ctl dp_ctl;
    t_dp_sts dp_sts;

    // Controller: accept requests, hold the input while a packet is walked out.
    cpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (dp_sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (dp_ctl)
    );

    // Datapath: packet state, payload RAM, fetch and output registers.
    cpf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (dp_ctl),
        .i_message_id     (i_message_id),
        .i_function_code  (i_function_code),
        .i_data_byte      (i_data_byte),
        .i_out_stall      (i_out_stall),
        .o_sts            (dp_sts),
        .o_out_valid      (o_out_valid),
        .o_packet_byte    (o_packet_byte),
        .o_last_in_packet (o_last_in_packet),
        .o_overflow_seen  (o_overflow_seen)
    );

    // An accepted finish request must close the input on the next cycle.
    a_finish_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_FINISH) |=> o_in_stall)
        else $error("input not stalled after finish request");

    // Fetching the final byte must reopen the input.
    a_done_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_sts.fetch_done |=> !o_in_stall)
        else $error("input still stalled after last byte fetched");

    // Fetch is only commanded while the input is closed.
    a_fetch_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctl.fetch_en |-> o_in_stall)
        else $error("fetch active while input open");

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the command packet framer: queued requests, byte scoreboard.
module tb_top import cpf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    localparam int STIM_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_REPORTS  = 10;

    // One request as the driver presents it on the input channel.
    typedef struct {
        t_cmd        cmd;
        logic [15:0] msg_id;
        logic [7:0]  func_code;
        logic [7:0]  data;
    } t_framer_req;

    // One framed byte as it leaves the block.
    typedef struct {
        logic [7:0] pkt_byte;
        logic       last;
        logic       ovf;
    } t_packet_byte;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_command       = '0;
    logic [15:0] i_message_id    = '0;
    logic [7:0]  i_function_code = '0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_packet_byte;
    logic        o_last_in_packet;
    logic        o_overflow_seen;

    // Stimulus and scoreboard storage.
    t_framer_req  pending_reqs [$];
    t_packet_byte expected_bytes [$];

    int stim_items   = 0;
    int accepted_cnt = 0;
    int phase_len    = 0;
    int hold_trigger = 0;
    int hold_left    = 0;
    bit hold_fired   = 1'b0;
    int fail_cnt     = 0;

    // Shadow copy of the framer state, at its reset values.
    logic [7:0]  shadow_payload [PAYLOAD_MAX] = '{default: 8'h00};
    int unsigned shadow_len    = 0;
    logic [7:0]  shadow_xor    = 8'h00;
    logic [15:0] shadow_msg_id = 16'h0000;
    logic [7:0]  shadow_func   = 8'h00;
    logic        shadow_ovf    = 1'b0;

    command_packet_framer_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_message_id     (i_message_id),
        .i_function_code  (i_function_code),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_packet_byte    (o_packet_byte),
        .o_last_in_packet (o_last_in_packet),
        .o_overflow_seen  (o_overflow_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Count a failure; print only the first few so a broken build stays readable.
    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Advance the shadow state by one accepted request and queue the bytes it frames.
    task automatic frame_request(input t_framer_req r);
        logic [7:0]   hdr [HDR_BYTES];
        logic [7:0]   cks;
        t_packet_byte pb;
        int           total;
        case (r.cmd)
            CMD_BEGIN: begin
                shadow_msg_id = r.msg_id;
                shadow_func   = r.func_code;
                shadow_len    = 0;
                shadow_xor    = 8'h00;
                shadow_ovf    = 1'b0;
            end
            CMD_APPEND: begin
                // Drop the byte once the store is full, and remember that we did.
                if (shadow_len < PAYLOAD_MAX) begin
                    shadow_payload[shadow_len] = r.data;
                    shadow_len++;
                    shadow_xor ^= r.data;
                end else begin
                    shadow_ovf = 1'b1;
                end
            end
            CMD_FINISH: begin
                // Build the header: id big-endian, fixed bytes, length, function code.
                hdr[0] = shadow_msg_id[15:8];
                hdr[1] = shadow_msg_id[7:0];
                hdr[2] = HDR_SEC_BYTE;
                hdr[3] = HDR_ZERO;
                hdr[4] = HDR_ZERO;
                hdr[5] = LEN_BIAS + 8'(shadow_len);
                hdr[6] = shadow_func;
                // Fold every other header byte and the whole payload into the checksum.
                cks = CKS_SEED ^ shadow_xor;
                for (int i = 0; i < HDR_BYTES - 1; i++)
                    cks ^= hdr[i];
                hdr[HDR_BYTES - 1] = cks;
                total = HDR_BYTES + shadow_len;
                for (int i = 0; i < total; i++) begin
                    pb.pkt_byte = (i < HDR_BYTES) ? hdr[i] : shadow_payload[i - HDR_BYTES];
                    pb.last     = (i == total - 1);
                    pb.ovf      = shadow_ovf;
                    expected_bytes.insert(expected_bytes.size(), pb);
                end
            end
            default: begin
                // Unused command code: no state change, no bytes.
            end
        endcase
    endtask

    task automatic push_req(input t_cmd c, input logic [15:0] id, input logic [7:0] fc,
                            input logic [7:0] d);
        t_framer_req r;
        r.cmd       = c;
        r.msg_id    = id;
        r.func_code = fc;
        r.data      = d;
        pending_reqs.insert(pending_reqs.size(), r);
        if (c != CMD_UNUSED)
            stim_items++;
    endtask

    // Queue a request with random content in every field, used or not.
    task automatic push_rand(input t_cmd c);
        push_req(c, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Queue a well-formed packet: begin, n payload bytes, one or more finishes.
    task automatic queue_packet(input int n_bytes, input int n_finish);
        push_rand(CMD_BEGIN);
        repeat (n_bytes) push_rand(CMD_APPEND);
        repeat (n_finish) push_rand(CMD_FINISH);
    endtask

    // Idle profile: sender light / receiver heavy, then swapped, then no idling.
    function automatic int idle_phase();
        if (accepted_cnt < phase_len)
            return 0;
        if (accepted_cnt < 2 * phase_len)
            return 1;
        return 2;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 22;
            1:       return $urandom_range(99) < 55;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 55;
            1:       return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    // Request driver: predict on every accepted request, then offer the next one
    // or idle. Hold the payload steady while the block stalls it.
    always @(posedge i_clk) begin
        t_framer_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                nxt.cmd       = t_cmd'(i_command);
                nxt.msg_id    = i_message_id;
                nxt.func_code = i_function_code;
                nxt.data      = i_data_byte;
                frame_request(nxt);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() != 0 && !sender_idles()) begin
                    nxt = pending_reqs.pop_front();
                    i_in_valid      <= 1'b1;
                    i_command       <= nxt.cmd;
                    i_message_id    <= nxt.msg_id;
                    i_function_code <= nxt.func_code;
                    i_data_byte     <= nxt.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, fired once partway through the run, so the
    // output registers fill and the block stalls its request channel.
    always @(posedge i_clk) begin
        if (i_rst_n && !hold_fired && accepted_cnt >= hold_trigger) begin
            hold_fired <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver stall: random per phase, forced high during the hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= (hold_left != 0) || receiver_idles();
    end

    // Monitor: compare every accepted packet byte with the oldest expectation.
    always @(posedge i_clk) begin
        t_packet_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("unexpected byte %02h last %0b ovf %0b",
                                       o_packet_byte, o_last_in_packet, o_overflow_seen));
            end else begin
                want = expected_bytes.pop_front();
                if (o_packet_byte !== want.pkt_byte || o_last_in_packet !== want.last ||
                    o_overflow_seen !== want.ovf)
                    note_failure($sformatf(
                        "byte mismatch: exp %02h last %0b ovf %0b, got %02h last %0b ovf %0b",
                        want.pkt_byte, want.last, want.ovf,
                        o_packet_byte, o_last_in_packet, o_overflow_seen));
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        int n_bytes;

        // Directed: finish straight out of reset frames an empty packet with id 0.
        push_rand(CMD_FINISH);
        // All-ones id and function code, payload byte extremes.
        push_req(CMD_BEGIN, 16'hFFFF, 8'hFF, 8'($urandom));
        push_req(CMD_APPEND, 16'($urandom), 8'($urandom), 8'h00);
        push_req(CMD_APPEND, 16'($urandom), 8'($urandom), 8'hFF);
        push_req(CMD_APPEND, 16'($urandom), 8'($urandom), 8'hA5);
        push_rand(CMD_FINISH);
        // A second finish must repeat the same packet.
        push_rand(CMD_FINISH);
        // The unused code must leave the state alone.
        push_rand(CMD_UNUSED);
        push_rand(CMD_FINISH);
        // All-zero id and function code with an empty payload.
        push_req(CMD_BEGIN, 16'h0000, 8'h00, 8'($urandom));
        push_rand(CMD_FINISH);
        // Append after a finish joins the kept payload.
        push_req(CMD_APPEND, 16'($urandom), 8'($urandom), 8'h5A);
        push_rand(CMD_FINISH);
        push_req(CMD_BEGIN, 16'h8001, 8'h80, 8'($urandom));
        push_req(CMD_APPEND, 16'($urandom), 8'($urandom), 8'h01);
        push_rand(CMD_FINISH);

        // Random: open with an overfilled packet so the overflow path is hit early.
        queue_packet(PAYLOAD_MAX + 4, 1);
        while (stim_items < STIM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                // Mostly short packets, some long, a few at or past capacity.
                pick = $urandom_range(99);
                if (pick < 85)
                    n_bytes = $urandom_range(12);
                else if (pick < 95)
                    n_bytes = $urandom_range(PAYLOAD_MAX - 1, 13);
                else
                    n_bytes = $urandom_range(PAYLOAD_MAX + 6, PAYLOAD_MAX);
                queue_packet(n_bytes, ($urandom_range(9) == 0) ? 2 : 1);
            end else begin
                // Noise: stray appends, finishes, begins and the unused code.
                case ($urandom_range(3))
                    0:       push_rand(CMD_APPEND);
                    1:       push_rand(CMD_FINISH);
                    2:       push_rand(CMD_UNUSED);
                    default: push_rand(CMD_BEGIN);
                endcase
            end
        end
        phase_len    = pending_reqs.size() / 3;
        hold_trigger = phase_len / 2;

        // Hold reset for a few cycles, then release it once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in, then for every byte to come out.
        while (pending_reqs.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_bytes.size() != 0)
            note_failure($sformatf("%0d packet bytes never arrived", expected_bytes.size()));
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: stop a hung run.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD * 1ns);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
